/* src/aled_pkg.sv */
// ----------------------------------------------------------------------------
// aled_pkg
// Types and constants shared by the addressable LED frame driver.
// ----------------------------------------------------------------------------
package aled_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int PIX_BITS   = 24;
  localparam int BIT_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_PER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 3'd4;

  localparam logic [7:0] PERIOD_RST    = 8'd20;
  localparam logic [7:0] HIGH_ONE_RST  = 8'd15;
  localparam logic [7:0] HIGH_ZERO_RST = 8'd6;
  localparam logic [7:0] RESET_PER_RST = 8'd45;
  localparam logic [8:0] ACTIVE_RST    = 9'd256;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_START = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_LOAD  = 3'b010,
    ST_READY = 3'b100
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } led_out_t;

endpackage

/* src/addressable_led_frame_driver_core.sv */
// ----------------------------------------------------------------------------
// addressable_led_frame_driver_core
// Pixel store and serial line waveform generator for addressable LED strings.
//
//   channel  direction  handshake            beat
//   in_      input      in_valid / in_stall  led_in_t request
//   out_     output     out_valid / out_stall led_out_t result, one per request
//   cfg_     input      cfg_valid / cfg_ready register index and write data
//
// one request per cycle while in_stall is low, one result beat each, held in an output register
// a start request stalls the input in ST_LOAD while pixel 0 is read from the store
// reset and each accepted clear run a clearing pass over every store entry
// through the store port, with in_stall high throughout
// in_stall is also high while a finished result waits under out_stall
// ----------------------------------------------------------------------------
module addressable_led_frame_driver_core
  import aled_pkg::*;
#(
  parameter int MAX_PIXELS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  led_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output led_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PIXELS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_PIXELS);

  logic [7:0] period_r, high_one_r, high_zero_r, reset_per_r;
  logic [8:0] active_r;

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       sweep_r, sweep_nxt;
  logic                   sending_r, sending_nxt;
  logic                   gap_mode_r, gap_mode_nxt;
  logic [IDX_W-1:0]       pix_r, pix_nxt;
  logic [BIT_CNT_W-1:0]   bit_r, bit_nxt;
  logic [7:0]             tick_r, tick_nxt;
  logic [7:0]             gap_r, gap_nxt;
  logic [PIX_BITS-1:0]    shift_r, shift_nxt;
  logic                   out_valid_r;
  led_out_t               out_r, res;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [PIX_BITS-1:0]    mem_wdata, mem_rdata;

  logic                   accept;
  logic [7:0]             eff_period, duty, high_t;
  logic [CNT_W-1:0]       eff_count;
  logic                   period_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_READY) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      high_one_r  <= HIGH_ONE_RST;
      high_zero_r <= HIGH_ZERO_RST;
      reset_per_r <= RESET_PER_RST;
      active_r    <= ACTIVE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PERIOD:    period_r    <= cfg_data[7:0];
        CFG_HIGH_ONE:  high_one_r  <= cfg_data[7:0];
        CFG_HIGH_ZERO: high_zero_r <= cfg_data[7:0];
        CFG_RESET_PER: reset_per_r <= cfg_data[7:0];
        CFG_ACTIVE:    active_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_period = (period_r == 8'd0) ? 8'd1 : period_r;
    duty       = shift_r[PIX_BITS-1] ? high_one_r : high_zero_r;
    high_t     = (duty > eff_period) ? eff_period : duty;
    period_end = ({1'b0, tick_r} + 9'd1) >= {1'b0, eff_period};
    eff_count  = (active_r == 9'd0) ? CNT_W'(1) : CNT_W'(active_r);
    if (eff_count > MAX_CNT) begin
      eff_count = MAX_CNT;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    sending_nxt  = sending_r;
    gap_mode_nxt = gap_mode_r;
    pix_nxt      = pix_r;
    bit_nxt      = bit_r;
    tick_nxt     = tick_r;
    gap_nxt      = gap_r;
    shift_nxt    = shift_r;
    res          = '0;
    mem_we       = 1'b0;
    mem_waddr    = sweep_r;
    mem_wdata    = '0;
    mem_raddr    = sending_r ? IDX_W'(pix_r + IDX_W'(1)) : '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        sweep_nxt = IDX_W'(sweep_r + IDX_W'(1));
        if (sweep_r == LAST_IDX) begin
          state_nxt = ST_READY;
        end
      end
      ST_LOAD: begin
        shift_nxt = mem_rdata;
        state_nxt = ST_READY;
      end
      ST_READY: begin
        if (accept) begin
          if (in_data.req_type == REQ_TICK) begin
            if (sending_r) begin
              if (gap_mode_r) begin
                if (period_end) begin
                  tick_nxt = '0;
                  gap_nxt  = 8'(gap_r + 8'd1);
                  if (8'(gap_r + 8'd1) >= reset_per_r) begin
                    sending_nxt    = 1'b0;
                    gap_mode_nxt   = 1'b0;
                    gap_nxt        = '0;
                    bit_nxt        = '0;
                    res.frame_done = 1'b1;
                  end
                end else begin
                  tick_nxt = 8'(tick_r + 8'd1);
                end
              end else begin
                res.line_level = tick_r < high_t;
                if (!period_end) begin
                  tick_nxt = 8'(tick_r + 8'd1);
                end else begin
                  tick_nxt  = '0;
                  shift_nxt = {shift_r[PIX_BITS-2:0], 1'b0};
                  bit_nxt   = BIT_CNT_W'(bit_r + BIT_CNT_W'(1));
                  if (bit_r == BIT_CNT_W'(PIX_BITS - 1)) begin
                    bit_nxt = '0;
                    if ((CNT_W'(pix_r) + CNT_W'(1)) >= eff_count) begin
                      if (reset_per_r == 8'd0) begin
                        sending_nxt    = 1'b0;
                        gap_nxt        = '0;
                        res.frame_done = 1'b1;
                      end else begin
                        gap_mode_nxt = 1'b1;
                        gap_nxt      = '0;
                      end
                    end else begin
                      pix_nxt   = IDX_W'(pix_r + IDX_W'(1));
                      shift_nxt = mem_rdata;
                    end
                  end
                end
              end
            end
          end else if (sending_r) begin
            res.rejected = 1'b1;
          end else begin
            case (in_data.req_type)
              REQ_SET: begin
                if (CNT_W'(in_data.pixel_index) < MAX_CNT) begin
                  mem_we    = 1'b1;
                  mem_waddr = IDX_W'(in_data.pixel_index);
                  mem_wdata = {in_data.green, in_data.red, in_data.blue};
                end
              end
              REQ_CLEAR: begin
                state_nxt = ST_CLEAR;
                sweep_nxt = '0;
              end
              REQ_START: begin
                state_nxt    = ST_LOAD;
                sending_nxt  = 1'b1;
                gap_mode_nxt = 1'b0;
                pix_nxt      = '0;
                bit_nxt      = '0;
                tick_nxt     = '0;
                gap_nxt      = '0;
              end
              default: ;
            endcase
          end
          res.busy_res = sending_nxt;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        sweep_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      sending_r   <= 1'b0;
      gap_mode_r  <= 1'b0;
      pix_r       <= '0;
      bit_r       <= '0;
      tick_r      <= '0;
      gap_r       <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      sending_r  <= sending_nxt;
      gap_mode_r <= gap_mode_nxt;
      pix_r      <= pix_nxt;
      bit_r      <= bit_nxt;
      tick_r     <= tick_nxt;
      gap_r      <= gap_nxt;
      shift_r    <= shift_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  aled_ram #(
    .WIDTH (PIX_BITS),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rejected) |-> out_r.busy_res)
    else $error("rejected beat without busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.frame_done) |-> !out_r.busy_res)
    else $error("frame done beat while still busy");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r < BIT_CNT_W'(PIX_BITS))
    else $error("bit counter out of range");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> !mem_we)
    else $error("pixel store written during a frame");

  a_load_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> $past(accept && in_data.req_type == REQ_START))
    else $error("pixel load without a start beat");

endmodule

/* src/aled_ram.sv */
// ----------------------------------------------------------------------------
// aled_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aled_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* dv/tb_addressable_led_frame_driver_core.sv */
// ----------------------------------------------------------------------------
// tb_addressable_led_frame_driver_core
// Self-checking bench for the LED frame driver core. Requests and register
// writes are driven with random sender gaps and output stalls. Every result
// beat is compared, field by field, against a behavioral model of the pixel
// store, the bit timing and the latch gap that lives in the scoreboard.
// ----------------------------------------------------------------------------
module tb_addressable_led_frame_driver_core;
  import aled_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int TOTAL_ITEMS  = 1050;
  localparam int STORE_DEPTH  = 256;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class led_frame_scoreboard;
    bit [23:0] colors [STORE_DEPTH];
    bit        sending;
    bit        in_gap;
    int        pix_cnt;
    int        bit_cnt;
    int        tick_cnt;
    int        gap_cnt;
    bit [23:0] shifter;
    bit [7:0]  period;
    bit [7:0]  high_one;
    bit [7:0]  high_zero;
    bit [7:0]  gap_periods;
    bit [8:0]  active;
    led_out_t  expected_beats [$];
    int        errors;
    int        checked;
    int        frames_done;
    int        rejects;

    function new();
      foreach (colors[i]) colors[i] = '0;
      sending     = 1'b0;
      in_gap      = 1'b0;
      pix_cnt     = 0;
      bit_cnt     = 0;
      tick_cnt    = 0;
      gap_cnt     = 0;
      shifter     = '0;
      period      = PERIOD_RST;
      high_one    = HIGH_ONE_RST;
      high_zero   = HIGH_ZERO_RST;
      gap_periods = RESET_PER_RST;
      active      = ACTIVE_RST;
      errors      = 0;
      checked     = 0;
      frames_done = 0;
      rejects     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PERIOD:    period      = val[7:0];
        CFG_HIGH_ONE:  high_one    = val[7:0];
        CFG_HIGH_ZERO: high_zero   = val[7:0];
        CFG_RESET_PER: gap_periods = val[7:0];
        CFG_ACTIVE:    active      = val;
        default: ;
      endcase
    endfunction

    function void end_frame();
      sending  = 1'b0;
      in_gap   = 1'b0;
      tick_cnt = 0;
      gap_cnt  = 0;
      bit_cnt  = 0;
      frames_done++;
    endfunction

    function led_out_t predict_beat(led_in_t d);
      led_out_t r;
      int       per;
      int       high;
      int       count;
      bit       period_end;
      r     = '0;
      per   = (period == 0) ? 1 : int'(period);
      count = (active == 0) ? 1 : ((active > STORE_DEPTH) ? STORE_DEPTH : int'(active));
      if (d.req_type == REQ_TICK) begin
        if (sending) begin
          period_end = (tick_cnt + 1) >= per;
          if (in_gap) begin
            if (period_end) begin
              tick_cnt = 0;
              gap_cnt  = (gap_cnt + 1) & 255;
              if (gap_cnt >= gap_periods) begin
                end_frame();
                r.frame_done = 1'b1;
              end
            end else begin
              tick_cnt = (tick_cnt + 1) & 255;
            end
          end else begin
            high = shifter[23] ? int'(high_one) : int'(high_zero);
            if (high > per) high = per;
            r.line_level = (tick_cnt < high);
            if (!period_end) begin
              tick_cnt = (tick_cnt + 1) & 255;
            end else begin
              tick_cnt = 0;
              shifter  = shifter << 1;
              bit_cnt++;
              if (bit_cnt >= PIX_BITS) begin
                bit_cnt = 0;
                if (pix_cnt + 1 >= count) begin
                  if (gap_periods == 0) begin
                    end_frame();
                    r.frame_done = 1'b1;
                  end else begin
                    in_gap  = 1'b1;
                    gap_cnt = 0;
                  end
                end else begin
                  pix_cnt++;
                  shifter = colors[pix_cnt];
                end
              end
            end
          end
        end
      end else if (sending) begin
        r.rejected = 1'b1;
        rejects++;
      end else begin
        case (d.req_type)
          REQ_SET: colors[d.pixel_index] = {d.green, d.red, d.blue};
          REQ_CLEAR: foreach (colors[i]) colors[i] = '0;
          default: begin
            sending  = 1'b1;
            in_gap   = 1'b0;
            pix_cnt  = 0;
            bit_cnt  = 0;
            tick_cnt = 0;
            gap_cnt  = 0;
            shifter  = colors[0];
          end
        endcase
      end
      r.busy_res = sending;
      return r;
    endfunction

    function void note_request(led_in_t d);
      expected_beats.push_back(predict_beat(d));
    endfunction

    function void report(string field, logic want, logic got);
      errors++;
      $display("%0t: %s mismatch, expected %b actual %b", $time, field, want, got);
    endfunction

    function void check_result(led_out_t got);
      led_out_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat %b with none expected, expected nothing actual %b",
                 $time, got, got);
        return;
      end
      want = expected_beats.pop_front();
      checked++;
      if (got.line_level !== want.line_level) report("line_level", want.line_level, got.line_level);
      if (got.busy_res !== want.busy_res) report("busy_res", want.busy_res, got.busy_res);
      if (got.frame_done !== want.frame_done) report("frame_done", want.frame_done, got.frame_done);
      if (got.rejected !== want.rejected) report("rejected", want.rejected, got.rejected);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  led_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  led_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_frame_scoreboard sb;
  int cycle_count = 0;
  int items_sent = 0;
  int n_settings = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;
  int rx_hold_left = 0;

  addressable_led_frame_driver_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d beats still expected",
             cycle_count, sb.expected_beats.size());
    $display("FAIL");
    $finish;
  end

  function automatic led_in_t make_req(req_t t, logic [7:0] idx, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b);
    led_in_t m;
    m.req_type    = t;
    m.pixel_index = idx;
    m.red         = r;
    m.green       = g;
    m.blue        = b;
    return m;
  endfunction

  function automatic led_in_t random_req(req_t t);
    return make_req(t, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] random_duty();
    return ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
  endfunction

  task automatic set_idling(idle_mode_t m);
    case (m)
      IDLE_SENDER:   begin tx_idle_pct = 76; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
      IDLE_BOTH:     begin tx_idle_pct = 15; rx_stall_pct = 15; end
      default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_req(led_in_t d);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(logic [7:0] per, logic [7:0] h1, logic [7:0] h0,
                            logic [7:0] rp, logic [8:0] act);
    drain();
    cfg_write(CFG_PERIOD, {1'b0, per});
    cfg_write(CFG_HIGH_ONE, {1'b0, h1});
    cfg_write(CFG_HIGH_ZERO, {1'b0, h0});
    cfg_write(CFG_RESET_PER, {1'b0, rp});
    cfg_write(CFG_ACTIVE, act);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // ticks until the frame and its latch gap are over, with refused requests mixed in
  task automatic ticks_until_idle(int noise_pct);
    while (sb.sending) begin
      if ($urandom_range(99) < noise_pct)
        send_req(random_req(req_t'($urandom_range(1, 3))));
      else
        send_req(random_req(REQ_TICK));
    end
  endtask

  task automatic run_frame(int n_sets, bit do_clear);
    led_in_t d;
    if (do_clear) send_req(random_req(REQ_CLEAR));
    repeat (n_sets) begin
      d = random_req(REQ_SET);
      if ($urandom_range(3) != 0) d.pixel_index = 8'($urandom_range(0, 3));
      send_req(d);
    end
    repeat ($urandom_range(0, 2)) send_req(random_req(REQ_TICK));
    send_req(random_req(REQ_START));
    ticks_until_idle(6);
    repeat ($urandom_range(0, 2)) send_req(random_req(REQ_TICK));
  endtask

  initial begin
    int phase;
    sb = new();
    set_idling(IDLE_NONE);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, store writes at the field extremes, clear, start, refusals
    send_req(make_req(REQ_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_req(make_req(REQ_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_req(make_req(REQ_SET, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(REQ_SET, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_req(make_req(REQ_SET, 8'h55, 8'hAA, 8'h55, 8'hAA));
    send_req(make_req(REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(REQ_SET, 8'h00, 8'hFF, 8'hA5, 8'h00));
    send_req(make_req(REQ_SET, 8'h01, 8'h00, 8'h0F, 8'h81));
    send_req(make_req(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00));
    send_req(make_req(REQ_SET, 8'h00, 8'h12, 8'h34, 8'h56));
    send_req(make_req(REQ_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_req(make_req(REQ_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    repeat (10) send_req(make_req(REQ_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    // shrink the frame in flight
    set_config(8'd3, 8'd2, 8'd1, 8'd2, 9'd1);
    ticks_until_idle(0);

    // slowest bit timing, then zero period, duty above period and the longest latch gap
    set_config(8'd255, 8'd255, 8'd0, 8'd255, 9'd256);
    send_req(make_req(REQ_SET, 8'h00, 8'h00, 8'hA0, 8'h00));
    send_req(make_req(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (260) send_req(random_req(REQ_TICK));
    set_idling(IDLE_RECEIVER);
    set_config(8'd0, 8'd255, 8'd0, 8'd255, 9'd1);
    ticks_until_idle(3);

    // pixel count above the store and no latch gap, then the frame is cut short
    set_idling(IDLE_NONE);
    set_config(8'd0, 8'd1, 8'd0, 8'd0, 9'd511);
    repeat (6) send_req(random_req(REQ_SET));
    send_req(make_req(REQ_SET, 8'h01, 8'h3C, 8'hC3, 8'h99));
    send_req(make_req(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00));
    repeat (60) send_req(random_req(REQ_TICK));
    set_config(8'd0, 8'd1, 8'd0, 8'd0, 9'd3);
    ticks_until_idle(0);

    // long receiver hold-off while requests keep coming
    set_config(8'd2, 8'd2, 8'd1, 8'd1, 9'd1);
    rx_hold_req = 400;
    run_frame(3, 1'b0);

    phase = 0;
    while (items_sent < TOTAL_ITEMS || phase < 4) begin
      set_idling(idle_mode_t'(phase % 4));
      set_config(($urandom_range(3) == 0) ? 8'($urandom_range(3, 6)) : 8'($urandom_range(0, 2)),
                 random_duty(), random_duty(), 8'($urandom_range(0, 3)),
                 9'($urandom_range(0, 3)));
      run_frame($urandom_range(0, 4), $urandom_range(7) == 0);
      phase++;
    end

    drain();
    repeat (20) @(negedge clk);
    $display("%0d requests under %0d register settings, %0d beats checked",
             items_sent, n_settings, sb.checked);
    $display("%0d frames finished, %0d requests refused while busy",
             sb.frames_done, sb.rejects);
    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/aled_pkg.sv
src/aled_ram.sv
src/addressable_led_frame_driver_core.sv
dv/tb_addressable_led_frame_driver_core.sv
